/* rtl/bbec_pkg.sv */
// Shared constants for the box blur with edge-clipped windows.
package bbec_pkg;

  // Default sizing of the line store and the window.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_RADIUS = 7;

  // Fixed widths of the stream fields and configuration registers.
  localparam int PIXEL_BITS   = 16;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int FW_BITS      = 13;
  localparam int FH_BITS      = 13;
  localparam int WS_BITS      = 4;
  localparam int ROW_BITS     = 12;
  localparam int ADDR_BITS    = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [FW_BITS-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [FH_BITS-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [WS_BITS-1:0] RST_WINDOW_SIZE  = 4'd3;

endpackage

/* rtl/bbec_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module bbec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bbec_div_cell.sv */
// One cell of the divider chain: resolves one quotient bit per cycle.
module bbec_div_cell #(
  parameter int NUMW = 24,
  parameter int DENW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            vld_in,
  input  logic [NUMW-1:0] num_in,
  input  logic [NUMW-1:0] quo_in,
  input  logic [DENW-1:0] rem_in,
  input  logic [DENW-1:0] den_in,
  output logic            vld_out,
  output logic [NUMW-1:0] num_out,
  output logic [NUMW-1:0] quo_out,
  output logic [DENW-1:0] rem_out,
  output logic [DENW-1:0] den_out
);

  logic [DENW:0]   trial;
  logic            ge;
  logic [DENW:0]   diff;
  logic [DENW-1:0] rem_next;

  // Bring down the next numerator bit and try a subtraction.
  always_comb begin
    trial    = {rem_in, num_in[NUMW-1]};
    ge       = trial >= {1'b0, den_in};
    diff     = trial - {1'b0, den_in};
    rem_next = ge ? diff[DENW-1:0] : trial[DENW-1:0];
  end

  // Hand the partial result on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
    num_out <= {num_in[NUMW-2:0], 1'b0};
    quo_out <= {quo_in[NUMW-2:0], ge};
    rem_out <= rem_next;
    den_out <= den_in;
  end

endmodule

/* rtl/box_blur_edge_clipped.sv */
// Box blur over raster-order planes: each output pixel is the rounded mean of the in-frame
// pixels within window_size/2 rows and columns, so edge windows are clipped and divided by
// their true pixel count. Input is taken only while the block is idle. An item that yields
// an output then keeps the block busy until its mean is ready. The clipped window holds
// rows*cols pixels (up to 9 for the reset window of 3, 225 for a window of 15): the window
// is summed through the single read port of the line store, one pixel a cycle, and the
// mean is formed by a chain of divider cells, one quotient bit per cell. An item that
// yields no output leaves the block idle. The line store has no clearing pass, as only pixels
// written earlier in the same plane are read. A finished pixel waits in an output register.
module box_blur_edge_clipped #(
  parameter int MAX_WIDTH  = bbec_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = bbec_pkg::DEF_MAX_RADIUS
) (
  input  logic                           clk,
  input  logic                           rst,
  // Pixel input stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bbec_pkg::PIXEL_BITS-1:0] s_tdata,  // [15:0] pixel_in
  input  logic                           s_tuser,  // [0] is_pad
  // Blurred pixel output stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bbec_pkg::PIXEL_BITS-1:0] m_tdata,  // [15:0] pixel_out
  output logic                           m_tlast,  // last_of_plane
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bbec_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import bbec_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EWW  = CW + 1;
  localparam int NR   = 2 * MAX_RADIUS + 1;
  localparam int SW   = $clog2(NR);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int NW   = $clog2(NR + 1);
  localparam int CNTW = $clog2(NR * NR + 1);
  localparam int SUMW = PIXEL_BITS + CNTW;
  localparam int AW   = $clog2(NR * MAX_WIDTH);
  localparam int KW   = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(NR - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_SUM, ST_FLUSH, ST_LAUNCH, ST_DIV
  } state_t;

  state_t state;

  // Configuration registers and derived geometry.
  logic [FW_BITS-1:0] frame_width;
  logic [FH_BITS-1:0] frame_height;
  logic [WS_BITS-1:0] window_size;
  logic [EWW-1:0]     ew_q;
  logic [FH_BITS-1:0] eh_q;
  logic [RW-1:0]      rad_q;
  logic [KW-1:0]      total_q;
  logic [KW-1:0]      delay_q;
  logic [EWW-1:0]     ew;
  logic [FH_BITS-1:0] eh;
  logic [RW-1:0]      rad;
  logic [2:0]         rad_raw;
  logic               cfg_wr;

  // Stream positions.
  logic [ROW_BITS-1:0] in_row;
  logic [CW-1:0]       in_col;
  logic [SW-1:0]       in_slot;
  logic [KW-1:0]       in_k;
  logic                draining;
  logic [ROW_BITS-1:0] out_row;
  logic [CW-1:0]       out_col;
  logic [SW-1:0]       out_slot;

  // Window sweep.
  logic [ROW_BITS-1:0] cur_r;
  logic [CW-1:0]       cur_c;
  logic [SW-1:0]       cur_slot;
  logic                cur_last;
  logic [SW-1:0]       rd_slot;
  logic [NW-1:0]       rows_left;
  logic [CW-1:0]       rd_col;
  logic [CW-1:0]       c0_q;
  logic [CW-1:0]       c1_q;
  logic [CNTW-1:0]     cnt_q;
  logic [SUMW-1:0]     sum_q;
  logic                rd_vld;

  // Output register.
  logic                  out_valid;
  logic [PIXEL_BITS-1:0] out_pixel;
  logic                  out_last;

  // Handshake and line store signals.
  logic                  in_take;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [PIXEL_BITS-1:0] ram_rdata;
  logic                  launch;
  logic                  pix_emit;
  logic                  plane_full;
  logic                  out_is_last;

  // Window bounds for the pixel under way.
  logic [RW-1:0]       dr;
  logic [RW-1:0]       dc;
  logic [ROW_BITS-1:0] r0;
  logic [ROW_BITS:0]   rr;
  logic [ROW_BITS-1:0] r1;
  logic [EWW-1:0]      cr;
  logic [CW-1:0]       c0;
  logic [CW-1:0]       c1;
  logic [NW-1:0]       nrow;
  logic [NW-1:0]       ncol;
  logic [SW:0]         slot_sum;
  logic [SW-1:0]       slot0;

  // Divider chain.
  logic [SUMW:0]   dv;
  logic [SUMW-1:0] dn [0:SUMW];
  logic [SUMW-1:0] dq [0:SUMW];
  logic [CNTW-1:0] drm [0:SUMW];
  logic [CNTW-1:0] dd [0:SUMW];

  // Clamped geometry from the registers.
  always_comb begin
    if (frame_width == '0) begin
      ew = EWW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      ew = EWW'(MAX_WIDTH);
    end else begin
      ew = EWW'(frame_width);
    end
    if (frame_height == '0) begin
      eh = FH_BITS'(1);
    end else if (32'(frame_height) > HEIGHT_LIMIT) begin
      eh = FH_BITS'(HEIGHT_LIMIT);
    end else begin
      eh = frame_height;
    end
    rad_raw = window_size[3:1];
    rad     = (32'(rad_raw) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_raw);
  end

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      REG_WINDOW_SIZE:  prdata = 32'(window_size);
      default:          prdata = '0;
    endcase
  end

  // Input acceptance and line store write.
  assign s_tready    = (state == ST_IDLE);
  assign in_take     = s_tvalid && s_tready;
  assign ram_we      = in_take && !draining && !s_tuser;
  assign ram_waddr   = AW'(in_slot) * AW'(MAX_WIDTH) + AW'(in_col);
  assign ram_raddr   = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(rd_col);
  assign plane_full  = (in_k + KW'(1)) >= total_q;
  assign pix_emit    = draining || (ram_we && (plane_full || in_k >= delay_q));
  assign out_is_last = ((FH_BITS'(out_row) + FH_BITS'(1)) >= eh_q)
                    && ((EWW'(out_col) + EWW'(1)) >= ew_q);

  bbec_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (NR * MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clipped window bounds and the ring slot of its first row.
  always_comb begin
    dr       = (cur_r > ROW_BITS'(rad_q)) ? rad_q : RW'(cur_r);
    dc       = (EWW'(cur_c) > EWW'(rad_q)) ? rad_q : RW'(cur_c);
    r0       = cur_r - ROW_BITS'(dr);
    rr       = (ROW_BITS + 1)'(cur_r) + (ROW_BITS + 1)'(rad_q);
    r1       = (rr > (ROW_BITS + 1)'(eh_q - FH_BITS'(1))) ?
               ROW_BITS'(eh_q - FH_BITS'(1)) : ROW_BITS'(rr);
    cr       = EWW'(cur_c) + EWW'(rad_q);
    c0       = cur_c - CW'(dc);
    c1       = (cr > (ew_q - EWW'(1))) ? CW'(ew_q - EWW'(1)) : CW'(cr);
    nrow     = NW'(r1 - r0 + ROW_BITS'(1));
    ncol     = NW'(c1 - c0 + CW'(1));
    slot_sum = (SW + 1)'(cur_slot) + (SW + 1)'(NR) - (SW + 1)'(dr);
    slot0    = (cur_slot >= SW'(dr)) ? (cur_slot - SW'(dr)) : SW'(slot_sum);
  end

  assign launch = (state == ST_LAUNCH) && !out_valid;

  // Sequencer, positions, accumulation and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      window_size  <= RST_WINDOW_SIZE;
      in_row       <= '0;
      in_col       <= '0;
      in_slot      <= '0;
      in_k         <= '0;
      draining     <= 1'b0;
      out_row      <= '0;
      out_col      <= '0;
      out_slot     <= '0;
      rd_vld       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (dv[SUMW]) begin
        out_valid <= 1'b1;
      end
      if (cfg_wr) begin
        // A register write restarts the plane.
        unique case (paddr[3:2])
          REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_BITS-1:0];
          REG_FRAME_HEIGHT: frame_height <= pwdata[FH_BITS-1:0];
          REG_WINDOW_SIZE:  window_size  <= pwdata[WS_BITS-1:0];
          default:          ;
        endcase
        if (paddr[3:2] inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_WINDOW_SIZE}) begin
          in_row   <= '0;
          in_col   <= '0;
          in_slot  <= '0;
          in_k     <= '0;
          draining <= 1'b0;
          out_row  <= '0;
          out_col  <= '0;
          out_slot <= '0;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (ram_we) begin
              // Advance the input position.
              if (plane_full) begin
                draining <= 1'b1;
                in_row   <= '0;
                in_col   <= '0;
                in_slot  <= '0;
                in_k     <= '0;
              end else if ((EWW'(in_col) + EWW'(1)) >= ew_q) begin
                in_col  <= '0;
                in_row  <= in_row + ROW_BITS'(1);
                in_slot <= (in_slot == LAST_SLOT) ? '0 : in_slot + SW'(1);
                in_k    <= in_k + KW'(1);
              end else begin
                in_col <= in_col + CW'(1);
                in_k   <= in_k + KW'(1);
              end
            end
            if (pix_emit) begin
              cur_r    <= out_row;
              cur_c    <= out_col;
              cur_slot <= out_slot;
              cur_last <= out_is_last;
              state    <= ST_SETUP;
              // Advance the output position, or restart after the plane's last pixel.
              if (out_is_last) begin
                in_row   <= '0;
                in_col   <= '0;
                in_slot  <= '0;
                in_k     <= '0;
                draining <= 1'b0;
                out_row  <= '0;
                out_col  <= '0;
                out_slot <= '0;
              end else if ((EWW'(out_col) + EWW'(1)) >= ew_q) begin
                out_col  <= '0;
                out_row  <= out_row + ROW_BITS'(1);
                out_slot <= (out_slot == LAST_SLOT) ? '0 : out_slot + SW'(1);
              end else begin
                out_col <= out_col + CW'(1);
              end
            end
          end
        end
        ST_SETUP: begin
          rd_slot   <= slot0;
          rows_left <= nrow - NW'(1);
          rd_col    <= c0;
          c0_q      <= c0;
          c1_q      <= c1;
          cnt_q     <= CNTW'(nrow) * CNTW'(ncol);
          sum_q     <= '0;
          state     <= ST_SUM;
        end
        ST_SUM: begin
          // One line store read per cycle across the window.
          rd_vld <= 1'b1;
          if (rd_col == c1_q) begin
            rd_col <= c0_q;
            if (rows_left == '0) begin
              state <= ST_FLUSH;
            end else begin
              rows_left <= rows_left - NW'(1);
              rd_slot   <= (rd_slot == LAST_SLOT) ? '0 : rd_slot + SW'(1);
            end
          end else begin
            rd_col <= rd_col + CW'(1);
          end
        end
        ST_FLUSH: begin
          state <= ST_LAUNCH;
        end
        ST_LAUNCH: begin
          if (launch) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dv[SUMW]) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (rd_vld) begin
        sum_q <= sum_q + SUMW'(ram_rdata);
      end
    end
    // Derived geometry, refreshed every cycle.
    ew_q    <= ew;
    eh_q    <= eh;
    rad_q   <= rad;
    total_q <= KW'(ew) * KW'(eh);
    delay_q <= KW'(rad) * KW'(ew) + KW'(rad);
    if (dv[SUMW]) begin
      out_pixel <= dq[SUMW][PIXEL_BITS-1:0];
      out_last  <= cur_last;
    end
  end

  // Rounded mean: (sum + count/2) / count through the divider chain.
  assign dv[0]  = launch;
  assign dn[0]  = sum_q + SUMW'(cnt_q >> 1);
  assign dq[0]  = '0;
  assign drm[0] = '0;
  assign dd[0]  = cnt_q;

  for (genvar g = 0; g < SUMW; g++) begin : g_div
    bbec_div_cell #(
      .NUMW (SUMW),
      .DENW (CNTW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .vld_in  (dv[g]),
      .num_in  (dn[g]),
      .quo_in  (dq[g]),
      .rem_in  (drm[g]),
      .den_in  (dd[g]),
      .vld_out (dv[g+1]),
      .num_out (dn[g+1]),
      .quo_out (dq[g+1]),
      .rem_out (drm[g+1]),
      .den_out (dd[g+1])
    );
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_pixel;
  assign m_tlast  = out_last;

  // A finished mean never lands on a result still waiting for transfer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    dv[SUMW] |-> !out_valid)
    else $error("divider result overwrote a pending output");

  // Only one pixel is in the divider chain at a time.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    $countones(dv) <= 1)
    else $error("more than one item in the divider chain");

  // The chain only delivers while the sequencer waits for it.
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    dv[SUMW] |-> state == ST_DIV)
    else $error("divider result outside the divide state");

  // A window always holds at least one pixel.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> cnt_q != '0)
    else $error("empty window count");

endmodule
